[rtl/sss_pkg.sv]
`default_nettype none
package sss_pkg;

  // Number of list slots kept per scanline.
  localparam int MAX_SPRITES = 10;
  localparam int IDX_W       = $clog2(MAX_SPRITES);
  localparam int CNT_W       = $clog2(MAX_SPRITES + 1);

  // Vertical bias of the OAM Y byte.
  localparam logic [7:0] SPRITE_Y_OFS = 8'd16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_ENTRY = 2'd1;
  localparam logic [1:0] FUNC_EMIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SPRITES_ENABLED = 2'd0;
  localparam logic [1:0] REG_TALL_SPRITES    = 2'd1;
  localparam logic [1:0] REG_COLOR_MODE      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [7:0]  x;
    logic [7:0]  attr;
    logic [13:0] addr;
    logic [5:0]  pal;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;
    logic latch;
    logic insert;
    logic emit_init;
    logic emit_step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic             out_free;
    logic             emit_last;
    logic [CNT_W-1:0] count;
  } stat_t;

endpackage
`default_nettype wire

[rtl/sss_ctrl.sv]
`default_nettype none
module sss_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [1:0]    func,
  input  wire sss_pkg::stat_t stat,
  output sss_pkg::cmd_t      cmd
);

  sss_pkg::state_t state_r, state_nxt;
  logic accept;

  // The input is ready exactly in the idle state.
  assign accept = in_tvalid && (state_r == sss_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sss_pkg::ST_IDLE: begin
        if (accept && func == sss_pkg::FUNC_ENTRY) begin
          state_nxt = sss_pkg::ST_ENTRY;
        end else if (accept && func == sss_pkg::FUNC_EMIT) begin
          state_nxt = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_ENTRY: begin
        state_nxt = sss_pkg::ST_IDLE;
      end
      sss_pkg::ST_EMIT: begin
        if (stat.out_free && stat.emit_last) begin
          state_nxt = sss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sss_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      sss_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.start     = accept && func == sss_pkg::FUNC_START;
        cmd.latch     = accept && func == sss_pkg::FUNC_ENTRY;
        cmd.emit_init = accept && func == sss_pkg::FUNC_EMIT;
      end
      sss_pkg::ST_ENTRY: begin
        cmd.insert = 1'b1;
      end
      sss_pkg::ST_EMIT: begin
        cmd.emit_step = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sss_datapath.sv]
`default_nettype none
module sss_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic                           cfg_data,
  input  wire logic [sss_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire sss_pkg::cmd_t                  cmd,
  output sss_pkg::stat_t                      stat,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [sss_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);

  localparam int MAXS  = sss_pkg::MAX_SPRITES;
  localparam int CNT_W = sss_pkg::CNT_W;
  localparam int IDX_W = sss_pkg::IDX_W;

  logic enabled_r, tall_r, color_r;
  logic [7:0] scan_line_r;
  logic       stopped_r;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] k_r;
  logic [7:0] ent_y_r, ent_x_r, ent_tile_r, ent_attr_r;
  sss_pkg::slot_t list_r [MAXS];

  logic       out_valid_r, out_sv_r, out_last_r;
  sss_pkg::slot_t out_slot_r;

  // Entry decode, done in the cycle after the entry is latched.
  logic [7:0] d;
  logic       hit, take;
  logic [3:0] row;
  logic [7:0] tn;
  sss_pkg::slot_t new_slot;
  logic [CNT_W-1:0] first_gt, pos;
  logic       found;
  logic       room;
  logic       empty_emit;
  logic [CNT_W-1:0] k_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      tall_r    <= 1'b0;
      color_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sss_pkg::REG_SPRITES_ENABLED: enabled_r <= cfg_data;
        sss_pkg::REG_TALL_SPRITES:    tall_r    <= cfg_data;
        sss_pkg::REG_COLOR_MODE:      color_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    d   = scan_line_r + sss_pkg::SPRITE_Y_OFS - ent_y_r;
    hit = (d[7:4] == 4'd0) && (tall_r || !d[3]);
    row = d[3:0];
    if (ent_attr_r[6]) begin
      row = row ^ (tall_r ? 4'hf : 4'h7);
    end
    tn = tall_r ? {ent_tile_r[7:1], row[3]} : ent_tile_r;
    new_slot.row  = row;
    new_slot.x    = ent_x_r;
    new_slot.attr = ent_attr_r;
    new_slot.addr = {color_r & ent_attr_r[3], 1'b0, tn, row[2:0], 1'b0};
    new_slot.pal  = color_r ? {1'b1, ent_attr_r[2:0], 2'b00}
                            : {2'b00, ent_attr_r[4], ~ent_attr_r[4], 2'b00};
    take = !stopped_r && enabled_r && hit;
  end

  // First kept entry with a strictly greater X; colour mode places at the end instead.
  always_comb begin
    found    = 1'b0;
    first_gt = count_r;
    for (int i = 0; i < MAXS; i++) begin
      if (!found && CNT_W'(i) < count_r && list_r[i].x > ent_x_r) begin
        found    = 1'b1;
        first_gt = CNT_W'(i);
      end
    end
    pos  = color_r ? count_r : first_gt;
    room = pos < CNT_W'(MAXS);
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ent_y_r    <= in_tdata[15:8];
      ent_x_r    <= in_tdata[23:16];
      ent_tile_r <= in_tdata[31:24];
      ent_attr_r <= in_tdata[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert && take && room) begin
      for (int j = 0; j < MAXS; j++) begin
        if (CNT_W'(j) == pos) begin
          list_r[j] <= new_slot;
        end else if (j > 0 && CNT_W'(j) > pos) begin
          list_r[j] <= list_r[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_line_r <= '0;
      stopped_r   <= 1'b0;
      count_r     <= '0;
    end else if (cmd.start) begin
      scan_line_r <= in_tdata[7:0];
      stopped_r   <= !enabled_r;
      count_r     <= '0;
    end else if (cmd.insert && take && room) begin
      if (count_r < CNT_W'(MAXS)) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (color_r && count_r + CNT_W'(1) == CNT_W'(MAXS)) begin
        stopped_r <= 1'b1;
      end
    end
  end

  assign empty_emit = !enabled_r || count_r == '0;
  assign k_ext      = CNT_W'(k_r);

  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      k_r <= '0;
    end else if (cmd.emit_step) begin
      k_r <= k_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      if (empty_emit) begin
        out_sv_r   <= 1'b0;
        out_last_r <= 1'b1;
        out_slot_r <= '0;
      end else begin
        out_sv_r   <= 1'b1;
        out_last_r <= k_ext + CNT_W'(1) == count_r;
        out_slot_r <= list_r[k_r];
      end
    end
  end

  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.emit_last = empty_emit || (k_ext + CNT_W'(1) == count_r);
  assign stat.count     = count_r;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_slot_r.pal, out_slot_r.addr, out_slot_r.attr,
                       out_slot_r.x, out_slot_r.row};

endmodule
`default_nettype wire

[rtl/scanline_sprite_select.sv]
// Scanline sprite selection. A scanline begins with a start word (tuser 0)
// carrying the line number in tdata[7:0]; then the OAM entries follow one
// word each (tuser 1), and an emit word (tuser 2) sends out the chosen list,
// one result word per sprite with tlast on the final one and tuser set for a
// real sprite. With the sprite layer disabled or nothing chosen, the emit
// gives a single word with tuser low and tlast high. An OAM entry is
// registered, then decoded and placed into the ten-slot list in the following
// cycle, and an emit holds the input until its last result word is loaded
// into the output register, waiting out any output stall, since the list is
// read out of the slot registers one word at a time. There is no clearing
// pass after reset. The configuration port is always ready; it should only
// be written while the block is idle.
`default_nettype none
module scanline_sprite_select (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Configuration write channel.
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic                           cfg_data,
  // Input words.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata: line[7:0], oam_y[15:8], oam_x[23:16], oam_tile[31:24],
  //        oam_attr[39:32]
  input  wire logic [sss_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser: func[1:0]
  input  wire logic [1:0]                     in_tuser,
  // Result words.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata: row_offset[3:0], sprite_x[11:4], sprite_attr[19:12],
  //        row_address[33:20], palette_base[39:34]
  output logic [sss_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: slot_valid
  output logic                                out_tuser,
  output logic                                out_tlast
);

  sss_pkg::cmd_t  cmd;
  sss_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .func      (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  sss_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The list never holds more than its slot count.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= sss_pkg::CNT_W'(sss_pkg::MAX_SPRITES))
    else $error("sprite list count exceeds slot count");

  // A word without a sprite only ever appears as the end of a list.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("empty result word not marked last");

  // An OAM entry blocks the input for its placement cycle.
  a_entry_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == sss_pkg::FUNC_ENTRY |=> !in_tready)
    else $error("input ready during entry placement");

  // Insert and emit step come from different controller states, so no command mixes them.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.emit_step))
    else $error("insert and emit issued together");

endmodule
`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the scanline sprite selector.
//
// Words go in on the input stream (tuser = func, tdata = line and the four OAM
// bytes) and the chosen sprite list comes back on the result stream. A local
// predictor tracks the line, the list and the configuration. It works out the
// result words of each input word when that word is first offered. A word
// that is offered is never withdrawn, so this gives the same order as acceptance.
// Every result word is checked field by field against the oldest one waiting.
module tb_top;

  // Func code the block must ignore, and a register index that maps to nothing.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE    = 2'd3;

  // An OAM entry is registered and then placed, so the settle pause after the last
  // accepted word is plenty for the block to go idle before a register write.
  localparam int SETTLE_CYC  = 8;
  localparam int DRAIN_CYC   = 16;
  localparam int RAND_WORDS  = 240;
  // The receiver hold-off starts once this many words have gone in.
  localparam int PRESS_AT    = 80;
  localparam int PRESS_CYC   = 300;
  // Slowest run: about 300 words, each after the longest idle gap, and about 70
  // emits of up to 10 words that each wait the longest receiver gap, plus the
  // hold-off and the settle pauses. The limit is several times that.
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [3:0]  row;
    logic [7:0]  x;
    logic [7:0]  attr;
    logic [13:0] addr;
    logic [5:0]  pal;
  } sprite_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_t;

  // One row of the directed table. For ROW_CFG, code is the register index and
  // data[0] the value. For ROW_WORD, code is the func. Where has_typed is set,
  // the row's single result word is given by hand instead of by the predictor.
  typedef struct {
    row_kind_t      kind;
    logic [1:0]     code;
    logic [39:0]    data;
    bit             has_typed;
    sprite_result_t typed;
  } stim_row_t;

  // Empty or disabled list: one word, no sprite, marked last.
  localparam sprite_result_t NO_SPRITE = '{valid: 1'b0, last: 1'b1, row: 4'h0, x: 8'h00,
                                           attr: 8'h00, addr: 14'h0000, pal: 6'h00};
  // Line 0, Y = 16, X = 0xff, tile 0xff, attr 0, 8x8 mono: top row of tile 0xff.
  localparam sprite_result_t CORNER_SPRITE = '{valid: 1'b1, last: 1'b1, row: 4'h0,
                                               x: 8'hff, attr: 8'h00, addr: 14'h0ff0,
                                               pal: 6'h04};

  logic clk;
  logic rst_n = 1'b0;

  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [1:0]                    cfg_index = sss_pkg::REG_SPRITES_ENABLED;
  logic                          cfg_data  = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [sss_pkg::IN_DATA_W-1:0] in_tdata  = '0;
  logic [1:0]                    in_tuser  = sss_pkg::FUNC_START;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [sss_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;

  scanline_sprite_select u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: configuration, latched line, chosen list.
  logic           en_q, tall_q, color_q;
  logic [7:0]     cur_line;
  logic           line_done;
  int             slot_cnt;
  sprite_result_t slots [sss_pkg::MAX_SPRITES];

  // Expected result words, oldest first, and the words of the latest prediction.
  sprite_result_t exp_q [$];
  sprite_result_t fresh_q [$];
  stim_row_t      dir_tab [$];

  int  words_sent   = 0;
  int  rx_count     = 0;
  int  mismatch_cnt = 0;
  int  cycle_cnt    = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;
  bit  rx_hold      = 1'b0;
  int  rx_stall     = 0;
  int  rx_gap;

  // Idle length before a word: mostly none, often a few cycles, sometimes long.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [39:0] rand_bits();
    logic [31:0] lo, hi;
    lo = $urandom;
    hi = $urandom;
    return {hi[7:0], lo};
  endfunction

  // Decodes one OAM entry against the latched line and places it in the list.
  function automatic void place_entry(logic [39:0] d);
    logic [7:0]     y, x, tile, attr, dy, tn;
    logic [13:0]    addr;
    logic [5:0]     pal;
    sprite_result_t s;
    int             h, pos, top;
    y    = d[15:8];
    x    = d[23:16];
    tile = d[31:24];
    attr = d[39:32];
    h    = tall_q ? 16 : 8;
    dy   = cur_line + sss_pkg::SPRITE_Y_OFS - y;
    if (line_done || !en_q || int'(dy) >= h) return;
    // Y flip mirrors the row within the sprite's full height.
    if (attr[6]) dy = dy ^ 8'(h - 1);
    tn = tile;
    // A tall sprite uses an even/odd tile pair; the row's top bit picks the half.
    if (tall_q) tn[0] = dy[3];
    addr = {2'b00, tn, dy[2:0], 1'b0};
    if (color_q) begin
      addr[13] = attr[3];
      pal = {1'b1, attr[2:0], 2'b00};
    end else begin
      pal = attr[4] ? 6'd8 : 6'd4;
    end
    s = '{valid: 1'b1, last: 1'b0, row: dy[3:0], x: x, attr: attr, addr: addr, pal: pal};

    if (color_q) begin
      // Colour mode keeps OAM order and stops the scan once the list is full.
      if (slot_cnt >= sss_pkg::MAX_SPRITES) return;
      slots[slot_cnt] = s;
      slot_cnt++;
      if (slot_cnt >= sss_pkg::MAX_SPRITES) line_done = 1'b1;
      return;
    end
    // Mono mode: in front of the first entry with a strictly greater X.
    for (pos = 0; pos < slot_cnt; pos++)
      if (slots[pos].x > x) break;
    if (pos >= sss_pkg::MAX_SPRITES) return;
    if (pos == slot_cnt) begin
      slots[slot_cnt] = s;
      slot_cnt++;
      return;
    end
    // Shift the tail up; on a full list the last entry falls off.
    top = (slot_cnt < sss_pkg::MAX_SPRITES) ? slot_cnt : sss_pkg::MAX_SPRITES - 1;
    for (int i = top; i > pos; i--) slots[i] = slots[i-1];
    if (slot_cnt < sss_pkg::MAX_SPRITES) slot_cnt++;
    slots[pos] = s;
  endfunction

  // Advances the predictor by one input word; result words go to fresh_q.
  function automatic void scan_word(logic [1:0] f, logic [39:0] d);
    sprite_result_t r;
    case (f)
      sss_pkg::FUNC_START: begin
        cur_line  = d[7:0];
        slot_cnt  = 0;
        line_done = !en_q;
      end
      sss_pkg::FUNC_ENTRY: place_entry(d);
      sss_pkg::FUNC_EMIT: begin
        if (!en_q || slot_cnt == 0) begin
          fresh_q.push_back(NO_SPRITE);
        end else begin
          for (int k = 0; k < slot_cnt; k++) begin
            r = slots[k];
            r.last = (k == slot_cnt - 1);
            fresh_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(row_kind_t kind, logic [1:0] code, logic [39:0] data,
                                  bit has_typed = 1'b0, sprite_result_t typed = NO_SPRITE);
    stim_row_t row;
    row.kind      = kind;
    row.code      = code;
    row.data      = data;
    row.has_typed = has_typed;
    row.typed     = typed;
    dir_tab.push_back(row);
  endfunction

  // OAM entry word with random bytes, its Y mostly placed to hit the line.
  function automatic logic [39:0] make_entry(logic [7:0] ln);
    logic [39:0] d;
    logic [7:0]  dd;
    d = rand_bits();
    if ($urandom_range(0, 4) != 0) begin
      dd = 8'($urandom_range(0, tall_q ? 17 : 9));
      d[15:8] = ln + sss_pkg::SPRITE_Y_OFS - dd;
    end
    // A narrow X range gives many ties for the sort.
    if ($urandom_range(0, 1) == 1) d[23:16] = 8'($urandom_range(0, 7));
    return d;
  endfunction

  task automatic note_mismatch(string msg);
    $display("[%0t] result mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_result();
    sprite_result_t got, want;
    got = '{valid: out_tuser, last: out_tlast, row: out_tdata[3:0], x: out_tdata[11:4],
            attr: out_tdata[19:12], addr: out_tdata[33:20], pal: out_tdata[39:34]};
    if (exp_q.size() == 0) begin
      note_mismatch($sformatf("word %0d arrived with nothing expected", rx_count));
    end else begin
      want = exp_q.pop_front();
      if (got.valid !== want.valid)
        note_mismatch($sformatf("word %0d slot_valid %0h, want %0h", rx_count, got.valid,
                                want.valid));
      if (got.last !== want.last)
        note_mismatch($sformatf("word %0d last %0h, want %0h", rx_count, got.last,
                                want.last));
      if (got.row !== want.row)
        note_mismatch($sformatf("word %0d row_offset %0h, want %0h", rx_count, got.row,
                                want.row));
      if (got.x !== want.x)
        note_mismatch($sformatf("word %0d sprite_x %0h, want %0h", rx_count, got.x, want.x));
      if (got.attr !== want.attr)
        note_mismatch($sformatf("word %0d sprite_attr %0h, want %0h", rx_count, got.attr,
                                want.attr));
      if (got.addr !== want.addr)
        note_mismatch($sformatf("word %0d row_address %0h, want %0h", rx_count, got.addr,
                                want.addr));
      if (got.pal !== want.pal)
        note_mismatch($sformatf("word %0d palette_base %0h, want %0h", rx_count, got.pal,
                                want.pal));
    end
    rx_count++;
  endtask

  // Offers one word after a random gap and returns at the edge that accepts it.
  // cfg_valid is left high by a register write and lowered here.
  task automatic send_word(logic [1:0] f, logic [39:0] d, bit use_typed = 1'b0,
                           sprite_result_t typed = NO_SPRITE);
    int gap;
    gap = pick_gap(tx_calm);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    fresh_q.delete();
    scan_word(f, d);
    if (use_typed) exp_q.push_back(typed);
    else foreach (fresh_q[i]) exp_q.push_back(fresh_q[i]);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Waits until every expected word is back and the block has gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes one register. cfg_valid stays high so that writes can go back to back.
  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sss_pkg::REG_SPRITES_ENABLED: en_q    = val;
      sss_pkg::REG_TALL_SPRITES:    tall_q  = val;
      sss_pkg::REG_COLOR_MODE:      color_q = val;
      default: ;
    endcase
  endtask

  // One random scanline: a fresh configuration, maybe a stray word, then a
  // start, a run of entries (sometimes with a register change partway) and an emit.
  task automatic run_random_line();
    logic [7:0] ln;
    int         n_ent, mid, noise;
    settle();
    tx_calm = ($urandom_range(0, 4) == 0);
    write_reg(sss_pkg::REG_SPRITES_ENABLED, $urandom_range(0, 7) != 0);
    write_reg(sss_pkg::REG_TALL_SPRITES, 1'($urandom_range(0, 1)));
    write_reg(sss_pkg::REG_COLOR_MODE, 1'($urandom_range(0, 1)));
    noise = $urandom_range(0, 9);
    if (noise == 0) send_word(FUNC_UNUSED, rand_bits());
    else if (noise == 1) send_word(sss_pkg::FUNC_EMIT, rand_bits());
    else if (noise == 2) send_word(sss_pkg::FUNC_ENTRY, make_entry(cur_line));
    ln = 8'($urandom);
    send_word(sss_pkg::FUNC_START, {32'($urandom), ln});
    // Mostly short lines; now and then a long one that fills and overflows the list.
    n_ent = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 16) : $urandom_range(0, 10);
    mid   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_ent) : -1;
    for (int k = 0; k < n_ent; k++) begin
      if (k == mid) begin
        settle();
        if ($urandom_range(0, 1) == 1) write_reg(sss_pkg::REG_TALL_SPRITES, !tall_q);
        else write_reg(sss_pkg::REG_COLOR_MODE, !color_q);
      end
      send_word(sss_pkg::FUNC_ENTRY, make_entry(ln));
    end
    if ($urandom_range(0, 11) == 0) send_word(FUNC_UNUSED, rand_bits());
    send_word(sss_pkg::FUNC_EMIT, rand_bits());
    // During the hold-off a second emit is always offered, so it waits on the input.
    if (rx_hold || $urandom_range(0, 5) == 0) send_word(sss_pkg::FUNC_EMIT, rand_bits());
  endtask

  // Receiver: checks each accepted result word and paces tready with random
  // stalls, calm stretches, and the long hold-off from the pressure process.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if ($urandom_range(0, 63) == 0) rx_calm <= !rx_calm;
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall   <= rx_stall - 1;
    end else begin
      rx_gap = pick_gap(rx_calm);
      out_tready <= !rx_hold && (rx_gap == 0);
      rx_stall   <= (rx_gap > 0) ? rx_gap - 1 : 0;
    end
  end

  // Pressure: the receiver holds off for a long stretch while the sender keeps
  // offering, so that a pending emit backs up into the input.
  initial begin : hold_off
    while (words_sent < PRESS_AT) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (PRESS_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int rand_start;
    en_q      = 1'b0;
    tall_q    = 1'b0;
    color_q   = 1'b0;
    cur_line  = 8'h00;
    line_done = 1'b0;
    slot_cnt  = 0;

    // tdata below is {attr, tile, x, y, line}, one byte each.
    // Emit right after reset, with sprites disabled.
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00, 1'b1, NO_SPRITE);
    // Entry while disabled is ignored.
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_ff_ff_10_00);
    add_row(ROW_CFG,  sss_pkg::REG_SPRITES_ENABLED, 40'h1);
    // Entry before any start uses line 0; X and tile at their top.
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_ff_ff_10_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00, 1'b1, CORNER_SPRITE);
    // Unused func with every data bit set, then a repeated emit of the same list.
    add_row(ROW_WORD, FUNC_UNUSED, 40'hff_ff_ff_ff_ff);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'hff_ff_ff_ff_ff);
    // Tall colour sprites on the last line, with Y wrapping around 0.
    add_row(ROW_CFG,  sss_pkg::REG_TALL_SPRITES, 40'h1);
    add_row(ROW_CFG,  sss_pkg::REG_COLOR_MODE,   40'h1);
    add_row(ROW_WORD, sss_pkg::FUNC_START, 40'h00_00_00_00_ff);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'hff_ff_00_00_00);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_00_ff_ff_00);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h5a_a5_80_0f_ff);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h40_01_7f_08_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00);
    // Height and mode change partway through the line.
    add_row(ROW_CFG,  sss_pkg::REG_TALL_SPRITES, 40'h0);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h18_fe_7f_08_00);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_10_10_00_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00);
    add_row(ROW_CFG,  sss_pkg::REG_COLOR_MODE,   40'h0);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h10_33_7f_0a_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00);
    // Disabled at line start: the whole line is skipped even once re-enabled.
    add_row(ROW_CFG,  sss_pkg::REG_SPRITES_ENABLED, 40'h0);
    add_row(ROW_WORD, sss_pkg::FUNC_START, 40'h00_00_00_00_40);
    add_row(ROW_CFG,  sss_pkg::REG_SPRITES_ENABLED, 40'h1);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_00_20_50_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00, 1'b1, NO_SPRITE);
    // Disabled during the scan: later entries are ignored and the emit is empty.
    add_row(ROW_WORD, sss_pkg::FUNC_START, 40'h00_00_00_00_40);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_00_20_50_00);
    add_row(ROW_CFG,  sss_pkg::REG_SPRITES_ENABLED, 40'h0);
    add_row(ROW_WORD, sss_pkg::FUNC_ENTRY, 40'h00_00_10_50_00);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00, 1'b1, NO_SPRITE);
    // Re-enable; a write to the unmapped index changes nothing.
    add_row(ROW_CFG,  sss_pkg::REG_SPRITES_ENABLED, 40'h1);
    add_row(ROW_CFG,  REG_NONE,                     40'h1);
    add_row(ROW_WORD, sss_pkg::FUNC_EMIT,  40'h00_00_00_00_00);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].code, dir_tab[i].data[0]);
      end else begin
        send_word(dir_tab[i].code, dir_tab[i].data, dir_tab[i].has_typed, dir_tab[i].typed);
      end
    end

    rand_start = words_sent;
    while (words_sent - rand_start < RAND_WORDS) run_random_line();

    settle();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
